// ===== rtl/dbae_pkg.sv =====
// Package: shared item types, codes and controller/datapath interface structs.
package dbae_pkg;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_BLINK = 3'd1;
    localparam logic [2:0] KIND_ANIM  = 3'd2;
    localparam logic [2:0] KIND_LOAD  = 3'd3;
    localparam logic [2:0] KIND_WRITE = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  grid;
        logic [15:0] mask;
        logic [7:0]  periods;
        logic [3:0]  frame_count;
        logic [2:0]  frame_index;
        logic [2:0]  grid_count;
        logic [2:0]  word_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_grid;
        logic [15:0] segments;
        logic        last;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_BRD,
        S_BUPD,
        S_ARD,
        S_AUPD,
        S_HRD,
        S_HUSE,
        S_WRD,
        S_WUPD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic idx_clr;
        logic idx_inc;
        logic b_upd;
        logic a_upd;
        logic h_use;
        logic w_upd;
        logic emit_clr;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic blink_more;
        logic anim_more;
        logic fire;
        logic word_more;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/dbae_ctrl.sv =====
// Controller: sequences item decode, the tick walk and grid emission.
module dbae_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dbae_pkg::sts_t sts,
    output dbae_pkg::cmd_t cmd
);

    dbae_pkg::state_t state_reg;
    dbae_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbae_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbae_pkg::S_IDLE:
                if (in_valid) state_next = dbae_pkg::S_EXEC;
            dbae_pkg::S_EXEC:
                if (sts.is_tick) state_next = dbae_pkg::S_BRD;
                else if (sts.out_free) state_next = dbae_pkg::S_IDLE;
            dbae_pkg::S_BRD:
                state_next = sts.blink_more ? dbae_pkg::S_BUPD : dbae_pkg::S_ARD;
            dbae_pkg::S_BUPD:
                state_next = dbae_pkg::S_BRD;
            dbae_pkg::S_ARD:
                state_next = sts.anim_more ? dbae_pkg::S_AUPD : dbae_pkg::S_EMIT;
            dbae_pkg::S_AUPD:
                state_next = sts.fire ? dbae_pkg::S_HRD : dbae_pkg::S_ARD;
            dbae_pkg::S_HRD:
                state_next = dbae_pkg::S_HUSE;
            dbae_pkg::S_HUSE:
                state_next = dbae_pkg::S_WRD;
            dbae_pkg::S_WRD:
                state_next = sts.word_more ? dbae_pkg::S_WUPD : dbae_pkg::S_ARD;
            dbae_pkg::S_WUPD:
                state_next = dbae_pkg::S_WRD;
            dbae_pkg::S_EMIT:
                if (sts.out_free && sts.emit_last) state_next = dbae_pkg::S_IDLE;
            default:
                state_next = dbae_pkg::S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            dbae_pkg::S_IDLE: cmd.capture = in_valid;
            dbae_pkg::S_EXEC:
            begin
                cmd.idx_clr = sts.is_tick;
                cmd.exec    = !sts.is_tick && sts.out_free;
            end
            dbae_pkg::S_BRD:  cmd.idx_clr = !sts.blink_more;
            dbae_pkg::S_BUPD:
            begin
                cmd.b_upd   = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            dbae_pkg::S_ARD:  cmd.emit_clr = !sts.anim_more;
            dbae_pkg::S_AUPD:
            begin
                cmd.a_upd   = 1'b1;
                cmd.idx_inc = !sts.fire;
            end
            dbae_pkg::S_HRD:  ;
            dbae_pkg::S_HUSE: cmd.h_use = 1'b1;
            dbae_pkg::S_WRD:  cmd.idx_inc = !sts.word_more;
            dbae_pkg::S_WUPD: cmd.w_upd = 1'b1;
            dbae_pkg::S_EMIT: cmd.emit_load = sts.out_free;
            default:          ;
        endcase
    end

    assign in_stall = (state_reg != dbae_pkg::S_IDLE);

endmodule

// ===== rtl/dbae_dp.sv =====
// Datapath: program tables, frame store, framebuffer and output register.
module dbae_dp #(
    parameter int BLINK_SLOTS     = 32,
    parameter int ANIM_SLOTS      = 32,
    parameter int GRID_COUNT      = 6,
    parameter int FRAMES_PER_ANIM = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dbae_pkg::in_item_t  in_data,
    input  dbae_pkg::cmd_t      cmd,
    output dbae_pkg::sts_t      sts,
    output logic                out_valid,
    input  logic                out_stall,
    output dbae_pkg::out_item_t out_data
);

    localparam int BUW = $clog2(BLINK_SLOTS + 1);
    localparam int BIW = (BLINK_SLOTS > 1) ? $clog2(BLINK_SLOTS) : 1;
    localparam int AUW = $clog2(ANIM_SLOTS + 1);
    localparam int AIW = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;
    localparam int IW  = (BUW > AUW) ? BUW : AUW;
    localparam int PW  = (FRAMES_PER_ANIM > 1) ? $clog2(FRAMES_PER_ANIM) : 1;
    localparam int FS  = ANIM_SLOTS * FRAMES_PER_ANIM;
    localparam int FSW = (FS > 1) ? $clog2(FS) : 1;
    localparam int WS  = FS * GRID_COUNT;
    localparam int WAW = (WS > 1) ? $clog2(WS) : 1;
    localparam int GIW = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;

    // Program and frame stores
    logic [26:0]    blink_cfg_mem [BLINK_SLOTS];
    logic [7:0]     blink_cnt_mem [BLINK_SLOTS];
    logic [11:0]    anim_cfg_mem  [ANIM_SLOTS];
    logic [7:0]     anim_cnt_mem  [ANIM_SLOTS];
    logic [PW-1:0]  anim_pos_mem  [ANIM_SLOTS];
    logic [5:0]     hdr_mem       [FS];
    logic [15:0]    word_mem      [WS];

    logic [26:0]    blink_cfg_rd_reg;
    logic [7:0]     blink_cnt_rd_reg;
    logic [11:0]    anim_cfg_rd_reg;
    logic [7:0]     anim_cnt_rd_reg;
    logic [PW-1:0]  anim_pos_rd_reg;
    logic [5:0]     hdr_rd_reg;
    logic [15:0]    word_rd_reg;

    dbae_pkg::in_item_t item_reg;
    logic [BUW-1:0] blink_used_reg;
    logic [AUW-1:0] anim_used_reg;
    logic [3:0]     last_frames_reg;
    logic [IW-1:0]  idx_reg;
    logic [FSW-1:0] f_reg;
    logic [WAW-1:0] base_reg;
    logic [2:0]     first_reg;
    logic [2:0]     cnt_reg;
    logic [2:0]     w_reg;
    logic [GIW-1:0] emit_g_reg;
    logic [15:0]    fb_reg [GRID_COUNT];
    logic           out_valid_reg;
    dbae_pkg::out_item_t out_reg;

    // Decode of the captured item
    logic [1:0]     exec_status;
    logic           grid_ok;
    logic           load_ok;
    logic [31:0]    f_load_w;
    logic [31:0]    wa_load_w;
    logic [31:0]    f_tick_w;
    logic [31:0]    base_w;

    always_comb
    begin
        grid_ok = ({2'b0, item_reg.grid} < 5'(GRID_COUNT));
        load_ok = (anim_used_reg != '0)
            && ({4'b0, item_reg.frame_index} < {3'b0, last_frames_reg})
            && ({4'b0, item_reg.frame_index} < 7'(FRAMES_PER_ANIM))
            && (item_reg.grid_count != 3'd0)
            && (({2'b0, item_reg.grid} + {2'b0, item_reg.grid_count}) <= 5'(GRID_COUNT))
            && (item_reg.word_index < item_reg.grid_count);
        unique case (item_reg.kind)
            dbae_pkg::KIND_BLINK:
                if (blink_used_reg >= BUW'(BLINK_SLOTS)) exec_status = dbae_pkg::ST_FULL;
                else if (!grid_ok) exec_status = dbae_pkg::ST_BAD;
                else exec_status = dbae_pkg::ST_OK;
            dbae_pkg::KIND_ANIM:
                if (anim_used_reg >= AUW'(ANIM_SLOTS)) exec_status = dbae_pkg::ST_FULL;
                else if (item_reg.frame_count == 4'd0
                         || {3'b0, item_reg.frame_count} > 7'(FRAMES_PER_ANIM))
                    exec_status = dbae_pkg::ST_BAD;
                else exec_status = dbae_pkg::ST_OK;
            dbae_pkg::KIND_LOAD:
                exec_status = load_ok ? dbae_pkg::ST_OK : dbae_pkg::ST_BAD;
            dbae_pkg::KIND_WRITE:
                exec_status = grid_ok ? dbae_pkg::ST_OK : dbae_pkg::ST_BAD;
            default:
                exec_status = dbae_pkg::ST_BAD;
        endcase
        f_load_w  = 32'(anim_used_reg - AUW'(1)) * 32'(FRAMES_PER_ANIM)
                  + 32'(item_reg.frame_index);
        wa_load_w = 32'(f_load_w[FSW-1:0]) * 32'(GRID_COUNT) + 32'(item_reg.word_index);
    end

    logic do_blink_add;
    logic do_anim_add;
    logic do_load;
    assign do_blink_add = cmd.exec && item_reg.kind == dbae_pkg::KIND_BLINK
                       && exec_status == dbae_pkg::ST_OK;
    assign do_anim_add  = cmd.exec && item_reg.kind == dbae_pkg::KIND_ANIM
                       && exec_status == dbae_pkg::ST_OK;
    assign do_load      = cmd.exec && item_reg.kind == dbae_pkg::KIND_LOAD
                       && exec_status == dbae_pkg::ST_OK;

    // Blink counter step
    logic [8:0]  b_c;
    logic        b_fire;
    logic [2:0]  b_grid;
    logic [15:0] b_mask;
    assign b_grid = blink_cfg_rd_reg[26:24];
    assign b_mask = blink_cfg_rd_reg[23:8];
    assign b_c    = {1'b0, blink_cnt_rd_reg} + 9'd1;
    assign b_fire = (b_c >= {1'b0, blink_cfg_rd_reg[7:0]});

    // Animation counter and frame step
    logic [8:0]    a_c;
    logic          a_fire;
    logic [PW-1:0] pos_c;
    logic [PW-1:0] pos_n;
    always_comb
    begin
        a_c    = {1'b0, anim_cnt_rd_reg} + 9'd1;
        a_fire = (a_c >= {1'b0, anim_cfg_rd_reg[11:4]});
        pos_c  = (7'(anim_pos_rd_reg) >= 7'(FRAMES_PER_ANIM)) ? '0 : anim_pos_rd_reg;
        pos_n  = ((7'(pos_c) + 7'd1) >= {3'b0, anim_cfg_rd_reg[3:0]}) ? '0 : pos_c + PW'(1);
        f_tick_w = 32'(idx_reg[AIW-1:0]) * 32'(FRAMES_PER_ANIM) + 32'(pos_c);
        base_w   = 32'(f_reg) * 32'(GRID_COUNT);
    end

    // Blink store: write on add or counter update, registered read
    always_ff @(posedge clk)
    begin
        if (do_blink_add)
        begin
            blink_cfg_mem[blink_used_reg[BIW-1:0]] <=
                {item_reg.grid, item_reg.mask, item_reg.periods};
        end
        if (do_blink_add)
        begin
            blink_cnt_mem[blink_used_reg[BIW-1:0]] <= 8'd0;
        end
        else if (cmd.b_upd)
        begin
            blink_cnt_mem[idx_reg[BIW-1:0]] <= b_fire ? 8'd0 : b_c[7:0];
        end
        blink_cfg_rd_reg <= blink_cfg_mem[idx_reg[BIW-1:0]];
        blink_cnt_rd_reg <= blink_cnt_mem[idx_reg[BIW-1:0]];
    end

    // Animation store
    always_ff @(posedge clk)
    begin
        if (do_anim_add)
        begin
            anim_cfg_mem[anim_used_reg[AIW-1:0]] <= {item_reg.periods, item_reg.frame_count};
        end
        if (do_anim_add)
        begin
            anim_cnt_mem[anim_used_reg[AIW-1:0]] <= 8'd0;
        end
        else if (cmd.a_upd)
        begin
            anim_cnt_mem[idx_reg[AIW-1:0]] <= a_fire ? 8'd0 : a_c[7:0];
        end
        if (do_anim_add)
        begin
            anim_pos_mem[anim_used_reg[AIW-1:0]] <= '0;
        end
        else if (cmd.a_upd && a_fire)
        begin
            anim_pos_mem[idx_reg[AIW-1:0]] <= pos_n;
        end
        anim_cfg_rd_reg <= anim_cfg_mem[idx_reg[AIW-1:0]];
        anim_cnt_rd_reg <= anim_cnt_mem[idx_reg[AIW-1:0]];
        anim_pos_rd_reg <= anim_pos_mem[idx_reg[AIW-1:0]];
    end

    // Frame headers and words
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            hdr_mem[f_load_w[FSW-1:0]]   <= {item_reg.grid, item_reg.grid_count};
            word_mem[wa_load_w[WAW-1:0]] <= item_reg.mask;
        end
        hdr_rd_reg  <= hdr_mem[f_reg];
        word_rd_reg <= word_mem[base_reg + WAW'(w_reg)];
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture) item_reg <= in_data;
        if (cmd.a_upd) f_reg <= f_tick_w[FSW-1:0];
        if (cmd.h_use)
        begin
            first_reg <= hdr_rd_reg[5:3];
            cnt_reg   <= hdr_rd_reg[2:0];
            base_reg  <= base_w[WAW-1:0];
            w_reg     <= 3'd0;
        end
        else if (cmd.w_upd)
        begin
            w_reg <= w_reg + 3'd1;
        end
    end

    // Framebuffer write select and read select
    logic        fb_we;
    logic [4:0]  fb_waddr;
    logic [15:0] fb_wdata;
    logic [4:0]  fb_raddr;
    logic [15:0] fb_rd;
    logic [4:0]  copy_g;
    assign copy_g   = {2'b0, first_reg} + {2'b0, w_reg};
    assign fb_raddr = cmd.b_upd ? {2'b0, b_grid} : 5'(emit_g_reg);
    assign fb_rd    = fb_reg[fb_raddr[GIW-1:0]];

    always_comb
    begin
        fb_we    = 1'b0;
        fb_waddr = {2'b0, item_reg.grid};
        fb_wdata = item_reg.mask;
        if (cmd.exec && item_reg.kind == dbae_pkg::KIND_WRITE && grid_ok)
        begin
            fb_we = 1'b1;
        end
        else if (cmd.b_upd && b_fire && ({2'b0, b_grid} < 5'(GRID_COUNT)))
        begin
            fb_we    = 1'b1;
            fb_waddr = {2'b0, b_grid};
            fb_wdata = fb_rd ^ b_mask;
        end
        else if (cmd.w_upd && copy_g < 5'(GRID_COUNT) && {2'b0, w_reg} < 5'(GRID_COUNT))
        begin
            fb_we    = 1'b1;
            fb_waddr = copy_g;
            fb_wdata = word_rd_reg;
        end
    end

    // Control state: fill counts, walk index, framebuffer, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_used_reg  <= '0;
            anim_used_reg   <= '0;
            last_frames_reg <= 4'd0;
            idx_reg         <= '0;
            emit_g_reg      <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < GRID_COUNT; i++)
            begin
                fb_reg[i] <= 16'd0;
            end
        end
        else
        begin
            if (do_blink_add) blink_used_reg <= blink_used_reg + BUW'(1);
            if (do_anim_add)
            begin
                anim_used_reg   <= anim_used_reg + AUW'(1);
                last_frames_reg <= item_reg.frame_count;
            end
            if (cmd.idx_clr) idx_reg <= '0;
            else if (cmd.idx_inc) idx_reg <= idx_reg + IW'(1);
            if (cmd.emit_clr) emit_g_reg <= '0;
            else if (cmd.emit_load) emit_g_reg <= emit_g_reg + GIW'(1);
            if (fb_we) fb_reg[fb_waddr[GIW-1:0]] <= fb_wdata;
            if (cmd.exec || cmd.emit_load) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    // Load the result on a transfer slot
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_reg <= '{out_grid: 3'd0, segments: 16'd0, last: 1'b1, status: exec_status};
        end
        else if (cmd.emit_load)
        begin
            out_reg <= '{out_grid: 3'(emit_g_reg), segments: fb_rd,
                         last: sts.emit_last, status: dbae_pkg::ST_OK};
        end
    end

    assign sts.is_tick    = (item_reg.kind == dbae_pkg::KIND_TICK);
    assign sts.blink_more = (IW'(blink_used_reg) > idx_reg);
    assign sts.anim_more  = (IW'(anim_used_reg) > idx_reg);
    assign sts.fire       = a_fire;
    assign sts.word_more  = (w_reg < cnt_reg);
    assign sts.emit_last  = (emit_g_reg == GIW'(GRID_COUNT - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/display_blink_animation_engine.sv =====
// Top level: blink and animation engine for a segmented display.
// Non-tick items: captured, then decoded into the output register once it is free.
// Tick: walks the blink programs, then the animation programs, copying each firing
// animation's frame words into the framebuffer, then emits the grids one per cycle unless the
// output stalls. Results leave through an output register, so the next item is taken while
// one waits. Reset clears the framebuffer and both fill counts; tables need no clearing.
module display_blink_animation_engine #(
    parameter int BLINK_SLOTS     = 32,
    parameter int ANIM_SLOTS      = 32,
    parameter int GRID_COUNT      = 6,
    parameter int FRAMES_PER_ANIM = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dbae_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dbae_pkg::out_item_t out_data
);

    dbae_pkg::cmd_t cmd;
    dbae_pkg::sts_t sts;

    dbae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dbae_dp #(
        .BLINK_SLOTS     (BLINK_SLOTS),
        .ANIM_SLOTS      (ANIM_SLOTS),
        .GRID_COUNT      (GRID_COUNT),
        .FRAMES_PER_ANIM (FRAMES_PER_ANIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/dbae_checker.sv =====
// Port checker for the engine, bound to the top level.
module dbae_checker #(
    parameter int GRID_COUNT = 6
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input dbae_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input dbae_pkg::out_item_t out_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Error results close their item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != dbae_pkg::ST_OK |-> out_data.last)
        else $error("error result without last");

    // Error results carry no segments
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != dbae_pkg::ST_OK
        |-> out_data.segments == 16'd0 && out_data.out_grid == 3'd0)
        else $error("error result carries data");

    // Last result is a status result or the final grid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last
        |-> out_data.out_grid == 3'd0 || out_data.out_grid == 3'(GRID_COUNT - 1))
        else $error("last on a middle grid");

    // An accepted tick is followed by a stalled input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.kind == dbae_pkg::KIND_TICK |=> in_stall)
        else $error("input taken during tick");

endmodule

bind display_blink_animation_engine dbae_checker #(.GRID_COUNT(GRID_COUNT)) u_dbae_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
